// ===== hw/rtl/gtt_index_allocator_macros.svh =====
// Assertion macros shared by the GTT index allocator modules
`ifndef GTT_INDEX_ALLOCATOR_MACROS_SVH
`define GTT_INDEX_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GIA_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("gia check failed");
`define GIA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gia check failed");
`else
`define GIA_ASSERT(label, expr)
`define GIA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/gia_pkg.sv =====
// Types and constants of the GTT index allocator
`timescale 1ns / 1ps
package gia_pkg;
	localparam int AW = 21;          // page index / count width
	localparam int GW = 20;          // granted and release index width
	localparam int DW = 48;          // stream data width
	localparam logic [AW-1:0] TABLE_RESET = 21'd1048576;

	typedef enum logic [1:0] {
		KIND_PERS, KIND_TALLOC, KIND_TFREE, KIND_NONE
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK, ST_PFULL, ST_NOFIT, ST_UNKNOWN, ST_DOUBLE
	} status_t;

	typedef enum logic {
		CFG_TABLE, CFG_RESERVED
	} cfg_idx_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_DIV_LOAD, OP_DIV_STEP, OP_INIT_SET, OP_CAPTURE, OP_PERS,
		OP_RD_I, OP_NEXT_I, OP_NOFIT, OP_ALLOC_HIT, OP_ALLOC_WR, OP_UNKNOWN,
		OP_FREE_HIT, OP_DOUBLE, OP_HOLD_I, OP_RD_J, OP_NEXT_J, OP_MERGE,
		OP_RD_LAST, OP_MOVE, OP_EMIT
	} dp_op_t;

	typedef enum logic [4:0] {
		S_INIT_LOAD, S_INIT_DIV, S_INIT_SET, S_IDLE, S_DISPATCH, S_PERS,
		S_ARD, S_ACHK, S_AWR, S_FRD, S_FCHK, S_MRDI, S_MCHKI, S_MRDJ,
		S_MCHKJ, S_MMOVRD, S_MMOVWR, S_DONE
	} state_t;

	typedef struct packed {
		logic [AW-1:0] start;
		logic [AW-1:0] len;
		logic          busy;
	} entry_t;

	typedef struct packed {
		dp_op_t op;
	} gia_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  i_end;
		logic  j_end;
		logic  j_is_i;
		logic  rd_busy;
		logic  fit;
		logic  start_match;
		logic  touch;
		logic  out_busy;
	} gia_sts_t;
endpackage

// ===== hw/rtl/gia_dp.sv =====
// Datapath: config, transient share, block list memory, free sum and result register
`timescale 1ns / 1ps
`include "gtt_index_allocator_macros.svh"
module gia_dp import gia_pkg::*; #(
	parameter int MAX_BLOCKS = 64,
	parameter int TRANSIENT_DIVISOR = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  cfg_idx_t      cfg_index,
	input  logic [AW-1:0] cfg_wdata,
	input  logic [DW-1:0] in_tdata,
	input  logic [1:0]    in_tuser,
	input  gia_cmd_t      cmd,
	output gia_sts_t      sts,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [DW-1:0] m_tdata
);
	localparam int IW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int QL = $clog2(TRANSIENT_DIVISOR);
	localparam int QS = AW + QL;
	// reciprocal of the divisor, exact for every dividend below 2**AW
	localparam logic [AW:0] QM = (AW+1)'(((64'd1 << QS) / TRANSIENT_DIVISOR) + 64'd1);

	logic [AW-1:0] tec_q;
	logic [GW-1:0] rec_q;
	logic [CW-1:0] cnt_q, i_q, j_q;
	logic          out_valid_q;
	logic [AW-1:0] acc_q, usable_q, bump_q, ceil_q, free_q, pages_q;
	logic [GW-1:0] rel_q, gr_q;
	kind_t         kind_q;
	status_t       st_q;
	entry_t        ent_i_q, rd_q;
	logic [DW-1:0] out_q;
	entry_t        mem [MAX_BLOCKS];

	logic [AW-1:0] usable, ceil_init, quot;
	logic [2*AW:0] prod;
	logic          split, ab, ba;
	logic [AW:0]   pers_sum;
	logic          we, re;
	logic [IW-1:0] waddr, raddr;
	entry_t        wdata;

	always_comb begin
		usable = (tec_q > {1'b0, rec_q}) ? tec_q - {1'b0, rec_q} : '0;
		ceil_init = {1'b0, rec_q} + (usable_q - acc_q);
		prod = (2*AW+1)'(usable_q) * (2*AW+1)'(QM);
		quot = AW'(prod >> QS);
		pers_sum = {1'b0, bump_q} + {1'b0, pages_q};
		split = (rd_q.len != pages_q) && (cnt_q < CW'(MAX_BLOCKS));
		ab = ({1'b0, ent_i_q.start} + {1'b0, ent_i_q.len}) == {1'b0, rd_q.start};
		ba = ({1'b0, rd_q.start} + {1'b0, rd_q.len}) == {1'b0, ent_i_q.start};
	end

	always_comb begin
		we = 1'b0;
		waddr = i_q[IW-1:0];
		wdata = rd_q;
		re = 1'b0;
		raddr = i_q[IW-1:0];
		case (cmd.op)
			OP_INIT_SET: begin
				we = 1'b1;
				waddr = '0;
				wdata = '{start: ceil_init, len: acc_q, busy: 1'b0};
			end
			OP_ALLOC_HIT: begin
				we = split;
				waddr = cnt_q[IW-1:0];
				wdata = '{start: rd_q.start + pages_q, len: rd_q.len - pages_q, busy: 1'b0};
			end
			OP_ALLOC_WR: begin
				we = 1'b1;
				wdata = '{start: ent_i_q.start, len: pages_q, busy: 1'b1};
			end
			OP_FREE_HIT: begin
				we = 1'b1;
				wdata = '{start: rd_q.start, len: rd_q.len, busy: 1'b0};
			end
			OP_MERGE: begin
				we = 1'b1;
				wdata = '{start: ab ? ent_i_q.start : rd_q.start,
					len: ent_i_q.len + rd_q.len, busy: 1'b0};
			end
			OP_MOVE: begin
				we = 1'b1;
				waddr = j_q[IW-1:0];
			end
			OP_RD_I: re = 1'b1;
			OP_RD_J: begin
				re = 1'b1;
				raddr = j_q[IW-1:0];
			end
			OP_RD_LAST: begin
				re = 1'b1;
				raddr = cnt_q[IW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tec_q <= TABLE_RESET;
			rec_q <= '0;
			cnt_q <= CW'(1);
			i_q <= '0;
			j_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TABLE: tec_q <= cfg_wdata;
					CFG_RESERVED: rec_q <= cfg_wdata[GW-1:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_INIT_SET: begin
					cnt_q <= CW'(1);
					i_q <= '0;
					j_q <= '0;
				end
				OP_CAPTURE: i_q <= '0;
				OP_NEXT_I: i_q <= i_q + CW'(1);
				OP_ALLOC_HIT: if (split) begin
					cnt_q <= cnt_q + CW'(1);
				end
				OP_FREE_HIT: i_q <= '0;
				OP_HOLD_I: j_q <= '0;
				OP_NEXT_J: j_q <= j_q + CW'(1);
				OP_MERGE: cnt_q <= cnt_q - CW'(1);
				OP_MOVE: i_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_DIV_LOAD: usable_q <= usable;
			OP_DIV_STEP: acc_q <= quot;
			OP_INIT_SET: begin
				bump_q <= {1'b0, rec_q};
				ceil_q <= ceil_init;
				free_q <= acc_q;
			end
			OP_CAPTURE: begin
				kind_q <= kind_t'(in_tuser);
				pages_q <= in_tdata[AW-1:0];
				rel_q <= in_tdata[AW+GW-1:AW];
				gr_q <= '0;
				st_q <= ST_OK;
			end
			OP_PERS: begin
				if (pers_sum > {1'b0, ceil_q}) begin
					st_q <= ST_PFULL;
				end else begin
					gr_q <= bump_q[GW-1:0];
					bump_q <= pers_sum[AW-1:0];
				end
			end
			OP_NOFIT: st_q <= ST_NOFIT;
			OP_ALLOC_HIT: begin
				gr_q <= rd_q.start[GW-1:0];
				ent_i_q <= rd_q;
				free_q <= split ? free_q - pages_q : free_q - rd_q.len;
			end
			OP_UNKNOWN: st_q <= ST_UNKNOWN;
			OP_DOUBLE: st_q <= ST_DOUBLE;
			OP_FREE_HIT: free_q <= free_q + rd_q.len;
			OP_HOLD_I: ent_i_q <= rd_q;
			OP_EMIT: out_q <= {(DW-AW-3-GW)'(0), free_q, st_q, gr_q};
			default: ;
		endcase
	end

	assign sts.kind = kind_q;
	assign sts.i_end = i_q == cnt_q;
	assign sts.j_end = j_q == cnt_q;
	assign sts.j_is_i = j_q == i_q;
	assign sts.rd_busy = rd_q.busy;
	assign sts.fit = !rd_q.busy && (rd_q.len >= pages_q);
	assign sts.start_match = rd_q.start == {1'b0, rel_q};
	assign sts.touch = ab || ba;
	assign sts.out_busy = out_valid_q && !m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

	`GIA_ASSERT(a_cnt_range, cnt_q != '0 && cnt_q <= CW'(MAX_BLOCKS))
	`GIA_ASSERT(a_idx_range, i_q <= cnt_q && j_q <= cnt_q)
endmodule

// ===== hw/rtl/gia_ctrl.sv =====
// Controller state machine of the GTT index allocator
`timescale 1ns / 1ps
`include "gtt_index_allocator_macros.svh"
module gia_ctrl import gia_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  gia_sts_t sts,
	output gia_cmd_t cmd
);
	state_t state_q, nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT_LOAD;
		end else begin
			state_q <= nxt;
		end
	end

	always_comb begin
		nxt = state_q;
		cmd.op = OP_NOP;
		s_tready = 1'b0;
		case (state_q)
			S_INIT_LOAD: begin
				cmd.op = OP_DIV_LOAD;
				nxt = S_INIT_DIV;
			end
			S_INIT_DIV: begin
				cmd.op = OP_DIV_STEP;
				nxt = S_INIT_SET;
			end
			S_INIT_SET: begin
				cmd.op = OP_INIT_SET;
				nxt = S_IDLE;
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op = OP_CAPTURE;
					nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.kind)
					KIND_PERS: nxt = S_PERS;
					KIND_TALLOC: nxt = S_ARD;
					KIND_TFREE: nxt = S_FRD;
					default: nxt = S_DONE;
				endcase
			end
			S_PERS: begin
				cmd.op = OP_PERS;
				nxt = S_DONE;
			end
			S_ARD: begin
				if (sts.i_end) begin
					cmd.op = OP_NOFIT;
					nxt = S_DONE;
				end else begin
					cmd.op = OP_RD_I;
					nxt = S_ACHK;
				end
			end
			S_ACHK: begin
				if (sts.fit) begin
					cmd.op = OP_ALLOC_HIT;
					nxt = S_AWR;
				end else begin
					cmd.op = OP_NEXT_I;
					nxt = S_ARD;
				end
			end
			S_AWR: begin
				cmd.op = OP_ALLOC_WR;
				nxt = S_DONE;
			end
			S_FRD: begin
				if (sts.i_end) begin
					cmd.op = OP_UNKNOWN;
					nxt = S_DONE;
				end else begin
					cmd.op = OP_RD_I;
					nxt = S_FCHK;
				end
			end
			S_FCHK: begin
				if (!sts.start_match) begin
					cmd.op = OP_NEXT_I;
					nxt = S_FRD;
				end else if (sts.rd_busy) begin
					cmd.op = OP_FREE_HIT;
					nxt = S_MRDI;
				end else begin
					cmd.op = OP_DOUBLE;
					nxt = S_DONE;
				end
			end
			S_MRDI: begin
				if (sts.i_end) begin
					nxt = S_DONE;
				end else begin
					cmd.op = OP_RD_I;
					nxt = S_MCHKI;
				end
			end
			S_MCHKI: begin
				if (sts.rd_busy) begin
					cmd.op = OP_NEXT_I;
					nxt = S_MRDI;
				end else begin
					cmd.op = OP_HOLD_I;
					nxt = S_MRDJ;
				end
			end
			S_MRDJ: begin
				if (sts.j_end) begin
					cmd.op = OP_NEXT_I;
					nxt = S_MRDI;
				end else begin
					cmd.op = OP_RD_J;
					nxt = S_MCHKJ;
				end
			end
			S_MCHKJ: begin
				if (sts.j_is_i || sts.rd_busy || !sts.touch) begin
					cmd.op = OP_NEXT_J;
					nxt = S_MRDJ;
				end else begin
					cmd.op = OP_MERGE;
					nxt = S_MMOVRD;
				end
			end
			S_MMOVRD: begin
				cmd.op = OP_RD_LAST;
				nxt = S_MMOVWR;
			end
			S_MMOVWR: begin
				cmd.op = OP_MOVE;
				nxt = S_MRDI;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.op = OP_EMIT;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_INIT_LOAD;
		endcase
		if (cfg_we) begin
			nxt = S_INIT_LOAD;
			cmd.op = OP_NOP;
			s_tready = 1'b0;
		end
	end

	`GIA_ASSERT_NEXT(a_cfg_reinit, cfg_we, state_q == S_INIT_LOAD)
	`GIA_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, state_q == S_DISPATCH)
endmodule

// ===== hw/rtl/gtt_index_allocator.sv =====
// Top level of the GTT index allocator
`timescale 1ns / 1ps
// Page-index allocator for a translation table: one result transfer per request.
// After reset and after every config write the block initializes with s_tready low
// (a reciprocal multiply computes the transient share). A transient request scans
// the block list, reading and checking each entry in turn, in a memory with separate
// read and write addresses. A free scans the same way to find the block, then runs
// the merge loop over the free outer entries and the pairs they form, restarting
// the outer scan after each merge, so the cost grows with the square of the list
// length. One request is in work at a time; the result register lets the next
// request enter while a result waits.
module gtt_index_allocator import gia_pkg::*; #(
	parameter int MAX_BLOCKS = 64,
	parameter int TRANSIENT_DIVISOR = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  cfg_idx_t      cfg_index,
	input  logic [AW-1:0] cfg_wdata,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [DW-1:0] s_tdata,   // page_count[20:0], release_index[40:21]
	input  logic [1:0]    s_tuser,   // kind[1:0]
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [DW-1:0] m_tdata    // granted_index[19:0], status[22:20],
	                                 // free_transient_pages[43:23]
);
	gia_cmd_t cmd;
	gia_sts_t sts;

	gia_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts(sts),
		.cmd(cmd)
	);

	gia_dp #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.TRANSIENT_DIVISOR(TRANSIENT_DIVISOR)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_tdata(s_tdata),
		.in_tuser(s_tuser),
		.cmd(cmd),
		.sts(sts),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the GTT index allocator
`timescale 1ns / 1ps
module testbench;
	import gia_pkg::*;

	localparam int NBLK = 64;
	localparam int TDIV = 4;

	typedef struct packed {
		logic [19:0] granted;
		status_t     status;
		logic [20:0] free_pages;
	} grant_t;

	typedef struct {
		kind_t       kind;
		logic [20:0] pages;
		logic [19:0] rel;
		bit          typed;
		grant_t      res;
	} dir_row_t;

	logic          clk = 0;
	logic          arst_n = 0;
	logic          cfg_we = 0;
	cfg_idx_t      cfg_index = CFG_TABLE;
	logic [AW-1:0] cfg_wdata = '0;
	logic          s_tvalid = 0;
	logic          s_tready;
	logic [DW-1:0] s_tdata = '0;
	logic [1:0]    s_tuser = '0;
	logic          m_tvalid;
	logic          m_tready = 0;
	logic [DW-1:0] m_tdata;

	gtt_index_allocator u_top (.*);

	always #5 clk = ~clk;

	// allocator mirror
	int unsigned tbl_size, rsv_size, bump, ceil_idx, blk_cnt;
	int unsigned blk_start[NBLK], blk_len[NBLK];
	bit          blk_busy[NBLK];

	grant_t      grant_q[$];
	logic [19:0] live_q[$];
	int          errors = 0;
	int          sent = 0;
	bit          hold_done = 0;
	int          burst_left = 1;

	function automatic void carve_zones();
		int unsigned usable, trans;
		usable = (tbl_size > rsv_size) ? tbl_size - rsv_size : 0;
		trans = usable / TDIV;
		bump = rsv_size;
		ceil_idx = rsv_size + (usable - trans);
		for (int i = 0; i < NBLK; i++) begin
			blk_start[i] = 0;
			blk_len[i] = 0;
			blk_busy[i] = 0;
		end
		blk_start[0] = ceil_idx;
		blk_len[0] = trans;
		blk_cnt = 1;
	endfunction

	function automatic void coalesce();
		bit merged;
		bit ab, ba;
		merged = 1;
		while (merged) begin
			merged = 0;
			for (int i = 0; i < blk_cnt && !merged; i++) begin
				if (blk_busy[i])
					continue;
				for (int j = 0; j < blk_cnt && !merged; j++) begin
					if (i == j || blk_busy[j])
						continue;
					ab = (blk_start[i] + blk_len[i] == blk_start[j]);
					ba = (blk_start[j] + blk_len[j] == blk_start[i]);
					if (ab || ba) begin
						if (!ab)
							blk_start[i] = blk_start[j];
						blk_len[i] = blk_len[i] + blk_len[j];
						blk_busy[i] = 0;
						blk_cnt--;
						blk_start[j] = blk_start[blk_cnt];
						blk_len[j] = blk_len[blk_cnt];
						blk_busy[j] = blk_busy[blk_cnt];
						merged = 1;
					end
				end
			end
		end
	endfunction

	function automatic grant_t serve_request(kind_t k, logic [20:0] pages, logic [19:0] rel);
		int unsigned p, g, sum;
		status_t st;
		grant_t r;
		p = pages;
		g = 0;
		st = ST_OK;
		case (k)
			KIND_PERS: begin
				if (bump + p > ceil_idx)
					st = ST_PFULL;
				else begin
					g = bump;
					bump += p;
				end
			end
			KIND_TALLOC: begin
				st = ST_NOFIT;
				for (int i = 0; i < blk_cnt; i++) begin
					if (blk_busy[i] || blk_len[i] < p)
						continue;
					g = blk_start[i];
					st = ST_OK;
					if (blk_len[i] != p && blk_cnt < NBLK) begin
						blk_start[blk_cnt] = blk_start[i] + p;
						blk_len[blk_cnt] = blk_len[i] - p;
						blk_busy[blk_cnt] = 0;
						blk_cnt++;
					end
					blk_len[i] = p;
					blk_busy[i] = 1;
					break;
				end
			end
			KIND_TFREE: begin
				st = ST_UNKNOWN;
				for (int i = 0; i < blk_cnt; i++) begin
					if (blk_start[i] != rel)
						continue;
					if (!blk_busy[i])
						st = ST_DOUBLE;
					else begin
						blk_busy[i] = 0;
						st = ST_OK;
						coalesce();
					end
					break;
				end
			end
			default: ;
		endcase
		sum = 0;
		for (int i = 0; i < blk_cnt; i++)
			if (!blk_busy[i])
				sum += blk_len[i];
		r.granted = g[19:0];
		r.status = st;
		r.free_pages = sum[20:0];
		return r;
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [AW-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_TABLE)
			tbl_size = val;
		else
			rsv_size = val[19:0];
		carve_zones();
		live_q.delete();
		// init pass of the block
		repeat (40) @(posedge clk);
	endtask

	task automatic send_request(kind_t k, logic [20:0] pages, logic [19:0] rel,
			bit typed, grant_t typed_res);
		grant_t r;
		s_tvalid <= 1;
		s_tuser <= k;
		s_tdata <= {7'd0, rel, pages};
		do
			@(posedge clk);
		while (!s_tready);
		sent++;
		r = serve_request(k, pages, rel);
		if (k == KIND_TALLOC && r.status == ST_OK)
			live_q.push_back(r.granted);
		grant_q.push_back(typed ? typed_res : r);
		if (--burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 2) != 0) begin
				s_tvalid <= 0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (grant_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic random_phase(int n, int unsigned pmax);
		int sel, idx;
		kind_t k;
		logic [20:0] pages;
		logic [19:0] rel;
		grant_t none;
		none = '0;
		for (int it = 0; it < n; it++) begin
			sel = $urandom_range(0, 99);
			pages = 21'($urandom_range(0, pmax));
			if ($urandom_range(0, 19) == 0)
				pages = 21'($urandom);
			rel = 20'($urandom);
			if (sel < 30)
				k = KIND_PERS;
			else if (sel < 65)
				k = KIND_TALLOC;
			else if (sel < 95 && live_q.size() != 0) begin
				k = KIND_TFREE;
				idx = $urandom_range(0, live_q.size() - 1);
				rel = live_q[idx];
				live_q.delete(idx);
			end else if (sel < 98)
				k = KIND_TFREE;
			else
				k = KIND_NONE;
			send_request(k, pages, rel, 0, none);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		grant_t got, want;
		if (m_tvalid && m_tready) begin
			got.granted = m_tdata[19:0];
			got.status = status_t'(m_tdata[22:20]);
			got.free_pages = m_tdata[43:23];
			if (grant_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = grant_q.pop_front();
				if (got.granted !== want.granted) begin
					$display("%0t: granted_index expected %0d actual %0d",
						$time, want.granted, got.granted);
					errors++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, got.status);
					errors++;
				end
				if (got.free_pages !== want.free_pages) begin
					$display("%0t: free_transient_pages expected %0d actual %0d",
						$time, want.free_pages, got.free_pages);
					errors++;
				end
			end
		end
	end

	// receiver stalls, one long hold-off to back up the input
	initial begin
		int mode;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && sent >= 250) begin
				m_tready <= 0;
				repeat (3000) @(posedge clk);
				hold_done = 1;
			end
			if ($urandom_range(0, 63) == 0)
				mode = $urandom_range(0, 2);
			case (mode)
				0: m_tready <= 1;
				1: m_tready <= $urandom_range(0, 1);
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	initial begin
		#1s;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		dir_row_t dir_tbl[14];
		int unsigned cfg_tbl[9];
		int unsigned cfg_rsv[9];
		int unsigned pmax;
		dir_tbl = '{
			'{KIND_PERS,   21'd0,       20'd0,       1, '{20'd0, ST_OK, 21'd262144}},
			'{KIND_PERS,   21'd1,       20'd0,       1, '{20'd0, ST_OK, 21'd262144}},
			'{KIND_PERS,   21'd786432,  20'd0,       1, '{20'd0, ST_PFULL, 21'd262144}},
			'{KIND_PERS,   21'h1FFFFF,  20'hFFFFF,   1, '{20'd0, ST_PFULL, 21'd262144}},
			'{KIND_TALLOC, 21'd262145,  20'd0,       1, '{20'd0, ST_NOFIT, 21'd262144}},
			'{KIND_TALLOC, 21'h1FFFFF,  20'd0,       1, '{20'd0, ST_NOFIT, 21'd262144}},
			'{KIND_TALLOC, 21'd16,      20'd0,       1, '{20'd786432, ST_OK, 21'd262128}},
			'{KIND_TFREE,  21'd0,       20'd5,       1, '{20'd0, ST_UNKNOWN, 21'd262128}},
			'{KIND_TFREE,  21'd0,       20'd786448,  1, '{20'd0, ST_DOUBLE, 21'd262128}},
			'{KIND_TFREE,  21'd0,       20'd786432,  1, '{20'd0, ST_OK, 21'd262144}},
			'{KIND_NONE,   21'h1FFFFF,  20'hFFFFF,   1, '{20'd0, ST_OK, 21'd262144}},
			'{KIND_TALLOC, 21'd0,       20'd0,       0, '0},
			'{KIND_TFREE,  21'd0,       20'd786432,  0, '0},
			'{KIND_TALLOC, 21'd262144,  20'd0,       0, '0}
		};
		cfg_tbl = '{1, 64, 400, 4096, 1048576, 10, 2000, 1048576, 777};
		cfg_rsv = '{0, 0, 3, 1000, 1048575, 20, 0, 0, 123};

		tbl_size = TABLE_RESET;
		rsv_size = 0;
		carve_zones();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		repeat (40) @(posedge clk);

		foreach (dir_tbl[i])
			send_request(dir_tbl[i].kind, dir_tbl[i].pages, dir_tbl[i].rel,
				dir_tbl[i].typed, dir_tbl[i].res);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			write_reg(CFG_TABLE, AW'(cfg_tbl[ph]));
			write_reg(CFG_RESERVED, AW'(cfg_rsv[ph]));
			pmax = (tbl_size > rsv_size) ? (tbl_size - rsv_size) / 16 + 2 : 4;
			if (pmax > 4096)
				pmax = 4096;
			if (ph == 2)
				pmax = 2;
			random_phase(90, pmax);
			drain();
		end

		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
